// File: rtl/core/jst_pkg.sv
// Shared types and constants for the JSON stream tokenizer.
// No dependencies.
package jst_pkg;

  typedef enum logic [3:0] {
    EV_OBJ_OPEN  = 4'd0,
    EV_OBJ_CLOSE = 4'd1,
    EV_ARR_OPEN  = 4'd2,
    EV_ARR_CLOSE = 4'd3,
    EV_KEY_BYTE  = 4'd4,
    EV_KEY_END   = 4'd5,
    EV_STR_BYTE  = 4'd6,
    EV_STR_END   = 4'd7,
    EV_INTEGER   = 4'd8,
    EV_TRUE      = 4'd9,
    EV_FALSE     = 4'd10,
    EV_NULL      = 4'd11,
    EV_DONE      = 4'd12,
    EV_ERROR     = 4'd13
  } event_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_TRAILING    = 4'd1,
    ERR_PUNCT       = 4'd2,
    ERR_BAD_VALUE   = 4'd3,
    ERR_EXP_KEY     = 4'd4,
    ERR_CONTROL     = 4'd5,
    ERR_BAD_ESCAPE  = 4'd6,
    ERR_BAD_HEX     = 4'd7,
    ERR_SURROGATE   = 4'd8,
    ERR_UNTERM      = 4'd9,
    ERR_BAD_INT     = 4'd10,
    ERR_NON_INT     = 4'd11,
    ERR_RANGE       = 4'd12,
    ERR_TOO_DEEP    = 4'd13,
    ERR_MISSING     = 4'd14
  } error_code_e;

  // One classified request from the front to the back.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       is_ws;
    logic       is_digit;
    logic [4:0] hex_val;  // 16 = not a hex digit
  } req_t;

  // One result event.
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [6:0]  depth;
    logic [3:0]  code;
    logic        last;
  } ev_t;

  localparam int unsigned FifoDepth = 2;

endpackage

// File: rtl/core/jst_front.sv
// Front end: accepts input bytes, classifies them, and queues requests.
// Depends on jst_pkg.
module jst_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  output logic            req_valid_o,
  output jst_pkg::req_t   req_o,
  input  logic            req_take_i
);
  import jst_pkg::*;

  req_t       mem_q [FifoDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic       do_push, do_pop;
  logic [7:0] b;

  always_comb begin
    b = text_byte_i;
    cls.text_byte   = b;
    cls.end_of_text = end_of_text_i;
    cls.is_ws       = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    cls.is_digit    = (b >= 8'h30) && (b <= 8'h39);
    if (b >= 8'h30 && b <= 8'h39)      cls.hex_val = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) cls.hex_val = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) cls.hex_val = 5'(b - 8'h37);
    else                               cls.hex_val = 5'd16;
  end

  assign full_o      = (cnt_q == 2'(FifoDepth));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = mem_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// File: rtl/core/jst_back.sv
// Back end: parser state machine, container stack and number accumulator.
// Emits up to three events per request. Depends on jst_pkg.
module jst_back #(
  parameter int unsigned MaxNestDepth = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  jst_pkg::req_t req_i,
  output logic          req_take_o,
  output logic          ev_valid_o,
  output jst_pkg::ev_t  ev_o,
  input  logic          ev_take_i
);
  import jst_pkg::*;

  localparam int unsigned DW = $clog2(MaxNestDepth + 1);
  localparam int unsigned AW = (MaxNestDepth > 1) ? $clog2(MaxNestDepth) : 1;

  typedef enum logic [4:0] {
    PH_VALUE = 5'd0, PH_ARR_FIRST = 5'd1, PH_OBJ_FIRST = 5'd2, PH_KEY = 5'd3,
    PH_COLON = 5'd4, PH_STR = 5'd5, PH_STR_ESC = 5'd6, PH_STR_HEX = 5'd7,
    PH_KEY_STR = 5'd8, PH_KEY_ESC = 5'd9, PH_KEY_HEX = 5'd10,
    PH_NUM_SIGN = 5'd11, PH_NUM_ZERO = 5'd12, PH_NUM_DIGITS = 5'd13,
    PH_LITERAL = 5'd14, PH_AFTER = 5'd15
  } phase_e;

  phase_e          ph_q, ph_d;
  logic [DW-1:0]   dep_q, dep_d;
  logic            kinds_q [MaxNestDepth];
  logic            top_q, top_d;   // kind of innermost open container
  logic [63:0]     mag_q, mag_d;
  logic            neg_q, neg_d, ovf_q, ovf_d;
  logic [15:0]     cp_q, cp_d;
  logic [2:0]      hcnt_q, hcnt_d;
  logic [1:0]      lk_q, lk_d;
  logic [2:0]      li_q, li_d;
  logic            err_q, err_d;
  // pending event buffer (up to 3)
  ev_t             buf_q [3];
  logic [1:0]      bcnt_q, bidx_q;
  ev_t             e [3];
  logic [1:0]      n;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            wr_val;
  logic            pop_top;
  logic            busy;
  logic [7:0]      b;
  logic [DW-1:0]   edep;
  logic            deep;
  logic [63:0]     prod;
  logic [63:0]     limit_d;
  logic [7:0]      lit_ch;
  logic [2:0]      lit_len;
  logic [15:0]     cpn;
  logic [3:0]      ek;

  assign busy       = (bcnt_q != 2'd0);
  assign req_take_o = req_valid_i && (!busy || (bidx_q == bcnt_q - 2'd1 && ev_take_i));
  assign ev_valid_o = busy;
  assign ev_o       = buf_q[bidx_q];
  assign b          = req_i.text_byte;
  assign deep       = (dep_q >= DW'(MaxNestDepth));
  assign prod       = (mag_q << 3) + (mag_q << 1);
  // floor((2^63 - digit) / 10) drops by one only for digit 9
  assign limit_d    = (req_i.hex_val[3:0] == 4'd9) ? 64'd922337203685477579
                                                   : 64'd922337203685477580;

  function automatic ev_t mk(input logic [3:0] k, input logic [63:0] v,
                             input logic [DW-1:0] d, input logic [3:0] c);
    ev_t r;
    r.kind = k; r.value = v; r.depth = 7'(d); r.code = c; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    case ({lk_q, li_q})
      {2'd1, 3'd0}: lit_ch = "t";  {2'd1, 3'd1}: lit_ch = "r";
      {2'd1, 3'd2}: lit_ch = "u";  {2'd1, 3'd3}: lit_ch = "e";
      {2'd2, 3'd0}: lit_ch = "f";  {2'd2, 3'd1}: lit_ch = "a";
      {2'd2, 3'd2}: lit_ch = "l";  {2'd2, 3'd3}: lit_ch = "s";
      {2'd2, 3'd4}: lit_ch = "e";  {2'd3, 3'd0}: lit_ch = "n";
      {2'd3, 3'd1}: lit_ch = "u";  {2'd3, 3'd2}: lit_ch = "l";
      {2'd3, 3'd3}: lit_ch = "l";
      default:      lit_ch = 8'h00;
    endcase
    lit_len = (lk_q == 2'd2) ? 3'd5 : 3'd4;
  end

  always_comb begin : step
    logic        after;
    logic        key;
    logic [4:0]  base;
    logic [63:0] nv;
    ph_d = ph_q; dep_d = dep_q; top_d = top_q; mag_d = mag_q; neg_d = neg_q;
    ovf_d = ovf_q; cp_d = cp_q; hcnt_d = hcnt_q; lk_d = lk_q; li_d = li_q;
    err_d = err_q; n = 2'd0; wr_en = 1'b0; wr_addr = AW'(dep_q); wr_val = 1'b0;
    pop_top = 1'b0; after = 1'b0;
    e[0] = mk(EV_OBJ_OPEN, 64'd0, '0, ERR_NONE); e[1] = e[0]; e[2] = e[0];
    key  = (ph_q >= PH_KEY_STR) && (ph_q <= PH_KEY_HEX);
    base = key ? 5'(PH_KEY_STR) : 5'(PH_STR);
    ek   = key ? EV_KEY_BYTE : EV_STR_BYTE;
    cpn  = {cp_q[11:0], req_i.hex_val[3:0]};
    nv   = neg_q ? (64'd0 - mag_q) : mag_q;
    edep = dep_q;

    if (req_i.end_of_text) begin
      if (!err_q) begin
        case (ph_q)
          PH_NUM_ZERO, PH_NUM_DIGITS: begin
            if (ovf_q || mag_q > (neg_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF))
              e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_RANGE);
            else if (dep_q == '0) begin
              e[0] = mk(EV_INTEGER, nv, dep_q, ERR_NONE);
              e[1] = mk(EV_DONE, 64'd0, dep_q, ERR_NONE);
              n = 2'd2;
            end else begin
              e[0] = mk(EV_INTEGER, nv, dep_q, ERR_NONE);
              e[1] = mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT);
              n = 2'd2;
            end
            if (n == 2'd0) n = 2'd1;
          end
          PH_AFTER: begin
            e[0] = (dep_q == '0) ? mk(EV_DONE, 64'd0, dep_q, ERR_NONE)
                                 : mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT);
            n = 2'd1;
          end
          PH_VALUE:     begin e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_MISSING); n = 2'd1; end
          PH_ARR_FIRST: begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, deep ? ERR_TOO_DEEP : ERR_MISSING); n = 2'd1;
          end
          PH_OBJ_FIRST, PH_KEY: begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_EXP_KEY); n = 2'd1;
          end
          PH_COLON:     begin e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT); n = 2'd1; end
          PH_NUM_SIGN:  begin e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_INT); n = 2'd1; end
          PH_LITERAL:   begin e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_VALUE); n = 2'd1; end
          default:      begin e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_UNTERM); n = 2'd1; end
        endcase
      end
      ph_d = PH_VALUE; dep_d = '0; top_d = 1'b0; mag_d = '0; neg_d = 1'b0; ovf_d = 1'b0;
      cp_d = '0; hcnt_d = '0; lk_d = '0; li_d = '0; err_d = 1'b0;
    end else if (!err_q) begin
      case (ph_q)
        PH_VALUE, PH_ARR_FIRST: begin
          if (req_i.is_ws) begin
          end else if (ph_q == PH_ARR_FIRST && b == "]") begin
            e[0] = mk(EV_ARR_CLOSE, 64'd0, dep_q, ERR_NONE); n = 2'd1;
            if (dep_q != '0) begin dep_d = dep_q - 1'b1; pop_top = 1'b1; end
            ph_d = PH_AFTER;
          end else if (ph_q == PH_ARR_FIRST && deep) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_TOO_DEEP); n = 2'd1; err_d = 1'b1;
          end else if (b == "{" || b == "[") begin
            if (!deep) begin
              wr_en = 1'b1; wr_val = (b == "["); dep_d = dep_q + 1'b1; top_d = (b == "[");
              edep = dep_q + 1'b1;
            end
            e[0] = mk((b == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN, 64'd0, edep, ERR_NONE);
            n = 2'd1;
            ph_d = (b == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
          end else if (b == "\"") ph_d = PH_STR;
          else if (b == "t" || b == "f" || b == "n") begin
            lk_d = (b == "t") ? 2'd1 : (b == "f") ? 2'd2 : 2'd3; li_d = 3'd1;
            ph_d = PH_LITERAL;
          end else if (b == "-" || req_i.is_digit) begin
            neg_d = (b == "-"); ovf_d = 1'b0;
            mag_d = (b == "-") ? 64'd0 : 64'(req_i.hex_val[3:0]);
            ph_d = (b == "-") ? PH_NUM_SIGN : (b == "0") ? PH_NUM_ZERO : PH_NUM_DIGITS;
          end else begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_VALUE); n = 2'd1; err_d = 1'b1;
          end
        end
        PH_OBJ_FIRST, PH_KEY: begin
          if (req_i.is_ws) begin
          end else if (b == "}" && ph_q == PH_OBJ_FIRST) begin
            e[0] = mk(EV_OBJ_CLOSE, 64'd0, dep_q, ERR_NONE); n = 2'd1;
            if (dep_q != '0) begin dep_d = dep_q - 1'b1; pop_top = 1'b1; end
            ph_d = PH_AFTER;
          end else if (b == "\"") ph_d = PH_KEY_STR;
          else begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_EXP_KEY); n = 2'd1; err_d = 1'b1;
          end
        end
        PH_COLON: begin
          if (req_i.is_ws) begin
          end else if (b != ":") begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT); n = 2'd1; err_d = 1'b1;
          end else if (deep) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_TOO_DEEP); n = 2'd1; err_d = 1'b1;
          end else ph_d = PH_VALUE;
        end
        PH_NUM_SIGN: begin
          if (!req_i.is_digit) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_INT); n = 2'd1; err_d = 1'b1;
          end else begin
            mag_d = 64'(req_i.hex_val[3:0]);
            ph_d = (b == "0") ? PH_NUM_ZERO : PH_NUM_DIGITS;
          end
        end
        PH_NUM_ZERO, PH_NUM_DIGITS: begin
          if (ph_q == PH_NUM_DIGITS && req_i.is_digit) begin
            if (!ovf_q) begin
              if (mag_q > limit_d) ovf_d = 1'b1;
              else mag_d = prod + 64'(req_i.hex_val[3:0]);
            end
          end else if (b == "." || b == "e" || b == "E") begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_NON_INT); n = 2'd1; err_d = 1'b1;
          end else if (ovf_q ||
                       mag_q > (neg_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_RANGE); n = 2'd1; err_d = 1'b1;
          end else begin
            e[0] = mk(EV_INTEGER, nv, dep_q, ERR_NONE); n = 2'd1;
            ph_d = PH_AFTER; after = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (lk_q == 2'd0 || li_q >= lit_len || b != lit_ch) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_VALUE); n = 2'd1; err_d = 1'b1;
          end else if (li_q + 3'd1 == lit_len) begin
            e[0] = mk(EV_INTEGER + {2'b00, lk_q}, 64'd0, dep_q, ERR_NONE); n = 2'd1;
            lk_d = '0; li_d = '0; ph_d = PH_AFTER;
          end else li_d = li_q + 3'd1;
        end
        PH_AFTER: after = 1'b1;
        PH_STR, PH_KEY_STR: begin
          if (b == "\"") begin
            e[0] = mk(ek + 4'd1, 64'd0, dep_q, ERR_NONE); n = 2'd1;
            ph_d = key ? PH_COLON : PH_AFTER;
          end else if (b < 8'h20) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_CONTROL); n = 2'd1; err_d = 1'b1;
          end else if (b == "\\") ph_d = phase_e'(base + 5'd1);
          else begin e[0] = mk(ek, 64'(b), dep_q, ERR_NONE); n = 2'd1; end
        end
        PH_STR_ESC, PH_KEY_ESC: begin
          ph_d = phase_e'(base);
          n = 2'd1;
          case (b)
            "\"", "\\", "/": e[0] = mk(ek, 64'(b), dep_q, ERR_NONE);
            "b": e[0] = mk(ek, 64'd8, dep_q, ERR_NONE);
            "f": e[0] = mk(ek, 64'd12, dep_q, ERR_NONE);
            "n": e[0] = mk(ek, 64'd10, dep_q, ERR_NONE);
            "r": e[0] = mk(ek, 64'd13, dep_q, ERR_NONE);
            "t": e[0] = mk(ek, 64'd9, dep_q, ERR_NONE);
            "u": begin
              n = 2'd0; cp_d = '0; hcnt_d = '0; ph_d = phase_e'(base + 5'd2);
            end
            default: begin
              e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_ESCAPE); err_d = 1'b1; ph_d = ph_q;
            end
          endcase
        end
        PH_STR_HEX, PH_KEY_HEX: begin
          if (req_i.hex_val[4]) begin
            e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_HEX); n = 2'd1; err_d = 1'b1;
          end else begin
            cp_d = cpn;
            hcnt_d = hcnt_q + 3'd1;
            if (hcnt_q == 3'd3) begin
              hcnt_d = '0;
              if (cpn >= 16'hD800 && cpn <= 16'hDFFF) begin
                e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_SURROGATE); n = 2'd1; err_d = 1'b1;
              end else begin
                ph_d = phase_e'(base);
                if (cpn <= 16'h007F) begin
                  e[0] = mk(ek, 64'(cpn), dep_q, ERR_NONE); n = 2'd1;
                end else if (cpn <= 16'h07FF) begin
                  e[0] = mk(ek, 64'(8'hC0 | 8'(cpn >> 6)), dep_q, ERR_NONE);
                  e[1] = mk(ek, 64'(8'h80 | {2'b00, cpn[5:0]}), dep_q, ERR_NONE);
                  n = 2'd2;
                end else begin
                  e[0] = mk(ek, 64'(8'hE0 | {4'h0, cpn[15:12]}), dep_q, ERR_NONE);
                  e[1] = mk(ek, 64'(8'h80 | {2'b00, cpn[11:6]}), dep_q, ERR_NONE);
                  e[2] = mk(ek, 64'(8'h80 | {2'b00, cpn[5:0]}), dep_q, ERR_NONE);
                  n = 2'd3;
                end
              end
            end
          end
        end
        default: begin
          e[0] = mk(EV_ERROR, 64'd0, dep_q, ERR_BAD_VALUE); n = 2'd1; err_d = 1'b1;
        end
      endcase

      // byte that follows a value; may be the byte that ended a number
      if (after && !req_i.is_ws) begin
        if (dep_q == '0) begin
          e[n] = mk(EV_ERROR, 64'd0, dep_q, ERR_TRAILING); n = n + 2'd1; err_d = 1'b1;
        end else if (top_q) begin
          if (b == "]") begin
            e[n] = mk(EV_ARR_CLOSE, 64'd0, dep_q, ERR_NONE); n = n + 2'd1;
            dep_d = dep_q - 1'b1; pop_top = 1'b1; ph_d = PH_AFTER;
          end else if (b == ",") begin
            if (deep) begin
              e[n] = mk(EV_ERROR, 64'd0, dep_q, ERR_TOO_DEEP); n = n + 2'd1; err_d = 1'b1;
            end else ph_d = PH_VALUE;
          end else begin
            e[n] = mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT); n = n + 2'd1; err_d = 1'b1;
          end
        end else begin
          if (b == "}") begin
            e[n] = mk(EV_OBJ_CLOSE, 64'd0, dep_q, ERR_NONE); n = n + 2'd1;
            dep_d = dep_q - 1'b1; pop_top = 1'b1; ph_d = PH_AFTER;
          end else if (b == ",") ph_d = PH_KEY;
          else begin
            e[n] = mk(EV_ERROR, 64'd0, dep_q, ERR_PUNCT); n = n + 2'd1; err_d = 1'b1;
          end
        end
      end
    end
    if (n != 2'd0) e[n - 2'd1].last = 1'b1;
  end

  // container kind stack; the entry below the top is read when a container closes
  always_ff @(posedge clk_i) begin
    if (req_take_o && wr_en) kinds_q[wr_addr] <= wr_val;
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      buf_q[0] <= e[0]; buf_q[1] <= e[1]; buf_q[2] <= e[2];
    end
  end

  logic [AW-1:0] below_addr;
  assign below_addr = AW'(dep_q - 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_VALUE; dep_q <= '0; top_q <= 1'b0; mag_q <= '0; neg_q <= 1'b0;
      ovf_q <= 1'b0; cp_q <= '0; hcnt_q <= '0; lk_q <= '0; li_q <= '0; err_q <= 1'b0;
      bcnt_q <= '0; bidx_q <= '0;
    end else begin
      if (req_take_o) begin
        ph_q <= ph_d; dep_q <= dep_d; mag_q <= mag_d; neg_q <= neg_d; ovf_q <= ovf_d;
        cp_q <= cp_d; hcnt_q <= hcnt_d; lk_q <= lk_d; li_q <= li_d; err_q <= err_d;
        top_q <= pop_top ? ((dep_q >= 2) ? kinds_q[below_addr] : 1'b0) : top_d;
        bcnt_q <= n; bidx_q <= '0;
      end else if (ev_take_i && busy) begin
        if (bidx_q == bcnt_q - 2'd1) begin bcnt_q <= '0; bidx_q <= '0; end
        else bidx_q <= bidx_q + 2'd1;
      end
    end
  end
endmodule

// File: rtl/core/json_stream_tokenizer_top.sv
// Top level of the JSON stream tokenizer: front classifier and back parser.
// Depends on jst_pkg, jst_front, jst_back.
//
// One input item (a text byte or end-of-text mark) per cycle is accepted while full is
// low; the parser consumes one queued request per cycle while its result buffer is
// empty or its last event is being popped, and writes its zero to three events into
// that buffer. Each event takes one pop, so with pop held high throughput is one item
// per cycle unless an item yields several events; then no new item is taken until all
// are popped. A two-entry request queue decouples the byte input from the result side.
module json_stream_tokenizer_top #(
  parameter int unsigned MAX_NEST_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  event_kind_o,
  output logic signed [63:0] event_value_o,
  output logic [6:0]  nest_depth_o,
  output logic [3:0]  error_code_o,
  output logic        last_in_run_o
);
  import jst_pkg::*;

  logic  req_valid, req_take, ev_valid;
  req_t  req;
  ev_t   ev;

  jst_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .text_byte_i, .end_of_text_i,
    .req_valid_o(req_valid), .req_o(req), .req_take_i(req_take)
  );

  jst_back #(.MaxNestDepth(MAX_NEST_DEPTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_take_o(req_take),
    .ev_valid_o(ev_valid), .ev_o(ev), .ev_take_i(pop)
  );

  assign empty         = !ev_valid;
  assign event_kind_o  = ev.kind;
  assign event_value_o = ev.value;
  assign nest_depth_o  = ev.depth;
  assign error_code_o  = ev.code;
  assign last_in_run_o = ev.last;
endmodule

// File: tb/json_stream_tokenizer_top_test.sv
// Self-checking test of json_stream_tokenizer_top: directed table, then random JSON documents.
// Depends on jst_pkg and the RTL; an in-bench parser predicts every event.
module json_stream_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jst_pkg::*;

  localparam int MaxDepth = 64;
  localparam int CycleLimit = 200000;

  typedef enum int {
    P_VALUE, P_ARR_FIRST, P_OBJ_FIRST, P_KEY, P_COLON, P_STRING,
    P_NUM_SIGN, P_NUM_ZERO, P_NUM_DIGITS, P_LITERAL, P_AFTER
  } parse_state_e;

  typedef struct {
    event_kind_e kind;
    logic [63:0] value;
    logic [6:0]  depth;
    error_code_e code;
    logic        last;
  } token_ev_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    int         nev;
  } text_req_t;

  typedef struct {
    logic [7:0]  b;
    logic        eot;
    logic        chk;
    event_kind_e kind;
    error_code_e code;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] text_byte_i = 8'h00;
  logic end_of_text_i = 1'b0;
  logic pop = 1'b0;
  logic full, empty, last_in_run_o;
  logic [3:0] event_kind_o, error_code_o;
  logic signed [63:0] event_value_o;
  logic [6:0] nest_depth_o;

  json_stream_tokenizer_top #(.MAX_NEST_DEPTH(MaxDepth)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  token_ev_t want_q[$];
  text_req_t req_q[$];
  int errs = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold = 1'b0;

  // ---------------- predictor state ----------------
  parse_state_e st;
  int depth;
  bit kinds[MaxDepth];  // 0 object, 1 array
  logic [63:0] mag;
  bit neg, ovf, err_l, in_key;
  int str_sub;
  logic [15:0] cp;
  int hex_cnt, lit_k, lit_idx, run_n;
  string lit_word[3] = '{"true", "false", "null"};

  function automatic void tok_reset();
    st = P_VALUE; depth = 0; mag = '0; neg = 0; ovf = 0; err_l = 0;
    cp = '0; hex_cnt = 0; lit_k = 0; lit_idx = 0; in_key = 0; str_sub = 0;
    foreach (kinds[i]) kinds[i] = 0;
  endfunction

  function automatic void emit(event_kind_e k, logic [63:0] v, error_code_e c);
    token_ev_t e;
    if (run_n >= 3) return;
    e.kind = k; e.value = v; e.depth = depth[6:0]; e.code = c; e.last = 0;
    want_q.insert(want_q.size(), e);
    run_n++;
  endfunction

  function automatic void fail(error_code_e c);
    emit(EV_ERROR, '0, c);
    err_l = 1;
  endfunction

  function automatic bit is_ws(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void open_c(bit arr);
    if (depth < MaxDepth) begin
      kinds[depth] = arr;
      depth++;
    end
    emit(arr ? EV_ARR_OPEN : EV_OBJ_OPEN, '0, ERR_NONE);
    st = arr ? P_ARR_FIRST : P_OBJ_FIRST;
  endfunction

  function automatic void close_c(bit arr);
    emit(arr ? EV_ARR_CLOSE : EV_OBJ_CLOSE, '0, ERR_NONE);
    if (depth > 0) depth--;
    st = P_AFTER;
  endfunction

  function automatic void start_value(logic [7:0] b);
    if (b == "{") open_c(0);
    else if (b == "[") open_c(1);
    else if (b == "\"") begin
      st = P_STRING; in_key = 0; str_sub = 0;
    end else if (b == "t" || b == "f" || b == "n") begin
      lit_k = (b == "t") ? 1 : (b == "f") ? 2 : 3;
      lit_idx = 1;
      st = P_LITERAL;
    end else if (b == "-" || is_dig(b)) begin
      neg = (b == "-");
      ovf = 0;
      mag = (b == "-") ? 64'd0 : 64'(b - "0");
      st = (b == "-") ? P_NUM_SIGN : (b == "0") ? P_NUM_ZERO : P_NUM_DIGITS;
    end else fail(ERR_BAD_VALUE);
  endfunction

  function automatic bit finish_num();
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (ovf || mag > lim) begin
      fail(ERR_RANGE);
      return 0;
    end
    emit(EV_INTEGER, neg ? (64'd0 - mag) : mag, ERR_NONE);
    st = P_AFTER;
    return 1;
  endfunction

  function automatic void after_val(logic [7:0] b);
    bit top_arr;
    if (is_ws(b)) return;
    if (depth == 0) begin
      fail(ERR_TRAILING);
      return;
    end
    top_arr = kinds[depth-1];
    if (top_arr) begin
      if (b == "]") close_c(1);
      else if (b == ",") begin
        if (depth >= MaxDepth) fail(ERR_TOO_DEEP);
        else st = P_VALUE;
      end else fail(ERR_PUNCT);
    end else begin
      if (b == "}") close_c(0);
      else if (b == ",") st = P_KEY;
      else fail(ERR_PUNCT);
    end
  endfunction

  function automatic int hex_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction

  function automatic void str_byte(logic [7:0] b);
    event_kind_e ek;
    logic [7:0] c;
    int d;
    ek = in_key ? EV_KEY_BYTE : EV_STR_BYTE;
    if (str_sub == 0) begin
      if (b == "\"") begin
        emit(in_key ? EV_KEY_END : EV_STR_END, '0, ERR_NONE);
        st = in_key ? P_COLON : P_AFTER;
      end else if (b < 8'h20) fail(ERR_CONTROL);
      else if (b == "\\") str_sub = 1;
      else emit(ek, 64'(b), ERR_NONE);
    end else if (str_sub == 1) begin
      case (b)
        "\"": c = "\"";
        "\\": c = "\\";
        "/":  c = "/";
        "b":  c = 8'd8;
        "f":  c = 8'd12;
        "n":  c = 8'd10;
        "r":  c = 8'd13;
        "t":  c = 8'd9;
        "u": begin
          cp = '0; hex_cnt = 0; str_sub = 2;
          return;
        end
        default: begin
          fail(ERR_BAD_ESCAPE);
          return;
        end
      endcase
      emit(ek, 64'(c), ERR_NONE);
      str_sub = 0;
    end else begin
      d = hex_of(b);
      if (d > 15) begin
        fail(ERR_BAD_HEX);
        return;
      end
      cp = {cp[11:0], 4'(d)};
      hex_cnt++;
      if (hex_cnt < 4) return;
      hex_cnt = 0;
      if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
        fail(ERR_SURROGATE);
        return;
      end
      if (cp <= 16'h7F) emit(ek, 64'(cp), ERR_NONE);
      else if (cp <= 16'h7FF) begin
        emit(ek, 64'(8'hC0 | cp[10:6]), ERR_NONE);
        emit(ek, 64'(8'h80 | cp[5:0]), ERR_NONE);
      end else begin
        emit(ek, 64'(8'hE0 | cp[15:12]), ERR_NONE);
        emit(ek, 64'(8'h80 | cp[11:6]), ERR_NONE);
        emit(ek, 64'(8'h80 | cp[5:0]), ERR_NONE);
      end
      str_sub = 0;
    end
  endfunction

  function automatic void tok_byte(logic [7:0] b);
    logic [63:0] d;
    string w;
    case (st)
      P_VALUE: if (!is_ws(b)) start_value(b);
      P_ARR_FIRST: begin
        if (is_ws(b)) return;
        if (b == "]") close_c(1);
        else if (depth >= MaxDepth) fail(ERR_TOO_DEEP);
        else start_value(b);
      end
      P_OBJ_FIRST, P_KEY: begin
        if (is_ws(b)) return;
        if (b == "}" && st == P_OBJ_FIRST) close_c(0);
        else if (b == "\"") begin
          st = P_STRING; in_key = 1; str_sub = 0;
        end else fail(ERR_EXP_KEY);
      end
      P_COLON: begin
        if (is_ws(b)) return;
        if (b != ":") fail(ERR_PUNCT);
        else if (depth >= MaxDepth) fail(ERR_TOO_DEEP);
        else st = P_VALUE;
      end
      P_NUM_SIGN: begin
        if (!is_dig(b)) fail(ERR_BAD_INT);
        else begin
          mag = 64'(b - "0");
          st = (b == "0") ? P_NUM_ZERO : P_NUM_DIGITS;
        end
      end
      P_NUM_DIGITS, P_NUM_ZERO: begin
        if (st == P_NUM_DIGITS && is_dig(b)) begin
          d = 64'(b - "0");
          if (!ovf) begin
            if (mag > (64'h8000_0000_0000_0000 - d) / 10) ovf = 1;
            else mag = mag * 10 + d;
          end
        end else if (b == "." || b == "e" || b == "E") fail(ERR_NON_INT);
        else if (finish_num()) after_val(b);
      end
      P_LITERAL: begin
        w = lit_word[lit_k-1];
        if (lit_idx >= w.len() || b != w[lit_idx]) fail(ERR_BAD_VALUE);
        else begin
          lit_idx++;
          if (lit_idx == w.len()) begin
            emit(event_kind_e'(EV_INTEGER + lit_k), '0, ERR_NONE);
            lit_idx = 0;
            st = P_AFTER;
          end
        end
      end
      P_AFTER: after_val(b);
      default: str_byte(b);
    endcase
  endfunction

  function automatic void tok_end();
    if (err_l) return;
    if (st == P_NUM_ZERO || st == P_NUM_DIGITS)
      if (!finish_num()) return;
    case (st)
      P_AFTER: if (depth == 0) emit(EV_DONE, '0, ERR_NONE); else fail(ERR_PUNCT);
      P_VALUE: fail(ERR_MISSING);
      P_ARR_FIRST: fail(depth >= MaxDepth ? ERR_TOO_DEEP : ERR_MISSING);
      P_OBJ_FIRST, P_KEY: fail(ERR_EXP_KEY);
      P_COLON: fail(ERR_PUNCT);
      P_NUM_SIGN: fail(ERR_BAD_INT);
      P_LITERAL: fail(ERR_BAD_VALUE);
      default: fail(ERR_UNTERM);
    endcase
  endfunction

  // Predict one request and queue it for the driver.
  function automatic void send_req(logic [7:0] b, logic eot);
    text_req_t r;
    run_n = 0;
    if (eot) begin
      tok_end();
      tok_reset();
    end else if (!err_l) tok_byte(b);
    if (run_n > 0) want_q[$].last = 1;
    r.b = b; r.eot = eot; r.nev = run_n;
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic int queued_events();
    int n = 0;
    foreach (req_q[i]) n += req_q[i].nev;
    return n;
  endfunction

  // ---------------- document generator ----------------
  logic [7:0] doc[$];

  function automatic void put_b(logic [7:0] x);
    doc.insert(doc.size(), x);
  endfunction

  function automatic void put_s(string s);
    for (int i = 0; i < s.len(); i++) put_b(s[i]);
  endfunction

  function automatic void put_ws();
    string w = " \t\r\n";
    int n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    repeat (n) put_b(w[$urandom_range(0, 3)]);
  endfunction

  function automatic void gen_string();
    string esc = "\"\\/bfnrt";
    string hx = "0123456789abcdef";
    logic [15:0] c;
    logic [7:0] h;
    put_b("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          h = 8'($urandom_range(8'h20, 8'h7E));
          if (h == "\"" || h == "\\") h = "a";
          put_b(h);
        end
        2: put_b(8'($urandom_range(8'h80, 8'hFF)));
        3: begin
          put_b("\\");
          put_b(esc[$urandom_range(0, 7)]);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: c = 16'($urandom_range(0, 16'h7F));
            1: c = 16'($urandom_range(16'h80, 16'h7FF));
            2: c = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: c = 16'($urandom_range(0, 16'hFFFF));
          endcase
          put_s("\\u");
          for (int i = 3; i >= 0; i--) begin
            h = hx[c[4*i +: 4]];
            if (h >= "a" && $urandom_range(0, 1)) h = h - 8'h20;
            put_b(h);
          end
        end
      endcase
    end
    put_b("\"");
  endfunction

  function automatic void gen_int();
    case ($urandom_range(0, 7))
      0: put_s("9223372036854775807");
      1: put_s("-9223372036854775808");
      2: put_s("9223372036854775808");
      3: put_s("-9223372036854775809");
      4: put_s("0");
      5: put_s("-0");
      default: begin
        if ($urandom_range(0, 1)) put_b("-");
        put_b(8'("0" + $urandom_range(1, 9)));
        repeat ($urandom_range(0, 19)) put_b(8'("0" + $urandom_range(0, 9)));
      end
    endcase
  endfunction

  function automatic void gen_value(int lvl);
    int r = (lvl >= 3) ? $urandom_range(4, 9) : $urandom_range(0, 9);
    int n;
    put_ws();
    case (r)
      0, 1: begin
        put_b("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_b(",");
          put_ws();
          gen_string();
          put_ws();
          put_b(":");
          gen_value(lvl + 1);
        end
        put_ws();
        put_b("}");
      end
      2, 3: begin
        put_b("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_b(",");
          gen_value(lvl + 1);
        end
        put_ws();
        put_b("]");
      end
      4, 5: gen_string();
      6, 7: gen_int();
      default: put_s(lit_word[$urandom_range(0, 2)]);
    endcase
    put_ws();
  endfunction

  // Nesting right around the depth limit, mixed arrays and objects.
  function automatic void gen_deep();
    bit stk[$];
    int n = $urandom_range(MaxDepth - 1, MaxDepth + 1);
    repeat (n) begin
      stk.insert(stk.size(), 1'($urandom_range(0, 1)));
      if (stk[$]) put_b("[");
      else put_s("{\"k\":");
    end
    put_b("7");
    while (stk.size() > 0) put_b(stk.pop_back() ? "]" : "}");
  endfunction

  function automatic int gen_doc(bit deep);
    int p;
    doc.delete();
    if (deep) gen_deep();
    else if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 4)) put_b(8'($urandom_range(0, 255)));
    else gen_value(0);
    case ($urandom_range(0, 9))
      0: begin
        p = $urandom_range(0, doc.size() - 1);
        doc[p] = 8'($urandom_range(0, 255));
      end
      1: while (doc.size() > 1 && $urandom_range(0, 3) != 0) void'(doc.pop_back());
      2: put_b(8'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (doc[i]) send_req(doc[i], 1'b0);
    send_req(8'($urandom_range(0, 255)), 1'b1);
    return doc.size() + 1;
  endfunction

  // ---------------- directed table ----------------
  dir_row_t dir_tab[] = '{
    '{"[",   0, 1, EV_ARR_OPEN,  ERR_NONE},
    '{"]",   0, 1, EV_ARR_CLOSE, ERR_NONE},
    '{8'h00, 1, 1, EV_DONE,      ERR_NONE},
    '{8'hFF, 1, 1, EV_ERROR,     ERR_MISSING},
    '{"0",   0, 0, EV_DONE,      ERR_NONE},
    '{"1",   0, 1, EV_ERROR,     ERR_TRAILING},
    '{8'h00, 1, 0, EV_DONE,      ERR_NONE},
    '{"\"",  0, 0, EV_DONE,      ERR_NONE},
    '{8'hFF, 0, 1, EV_STR_BYTE,  ERR_NONE},
    '{8'h01, 0, 1, EV_ERROR,     ERR_CONTROL},
    '{8'h00, 1, 0, EV_DONE,      ERR_NONE},
    '{"t",   0, 0, EV_DONE,      ERR_NONE},
    '{"r",   0, 0, EV_DONE,      ERR_NONE},
    '{"x",   0, 1, EV_ERROR,     ERR_BAD_VALUE},
    '{8'h00, 1, 0, EV_DONE,      ERR_NONE},
    '{"-",   0, 0, EV_DONE,      ERR_NONE},
    '{8'h00, 1, 1, EV_ERROR,     ERR_BAD_INT},
    '{"1",   0, 0, EV_DONE,      ERR_NONE},
    '{".",   0, 1, EV_ERROR,     ERR_NON_INT},
    '{8'h00, 1, 0, EV_DONE,      ERR_NONE},
    '{"\"",  0, 0, EV_DONE,      ERR_NONE},
    '{"\\",  0, 0, EV_DONE,      ERR_NONE},
    '{8'h00, 1, 1, EV_ERROR,     ERR_UNTERM},
    '{"{",   0, 1, EV_OBJ_OPEN,  ERR_NONE},
    '{8'h00, 1, 1, EV_ERROR,     ERR_EXP_KEY}
  };

  // ---------------- driver and monitor ----------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (push && !full) void'(req_q.pop_front());
    if (rst_ni && !hold && req_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
      push <= 1'b1;
      text_byte_i <= req_q[0].b;
      end_of_text_i <= req_q[0].eot;
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    token_ev_t w;
    if (pop && !empty) begin
      if (want_q.size() == 0) begin
        $error("event with nothing expected: kind %0d", event_kind_o);
        errs++;
      end else begin
        w = want_q.pop_front();
        if (event_kind_o !== w.kind) begin
          $error("event_kind exp %0d got %0d", w.kind, event_kind_o); errs++;
        end
        if (event_value_o !== w.value) begin
          $error("event_value exp %0d got %0d", $signed(w.value), event_value_o); errs++;
        end
        if (nest_depth_o !== w.depth) begin
          $error("nest_depth exp %0d got %0d", w.depth, nest_depth_o); errs++;
        end
        if (error_code_o !== w.code) begin
          $error("error_code exp %0d got %0d", w.code, error_code_o); errs++;
        end
        if (last_in_run_o !== w.last) begin
          $error("last_in_run exp %0d got %0d", w.last, last_in_run_o); errs++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    int sent;
    bit held;
    tok_reset();
    send_idle = 16;
    recv_idle = 68;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].b, dir_tab[i].eot);
      if (dir_tab[i].chk && (req_q[$].nev == 0 || want_q[$].kind != dir_tab[i].kind ||
          want_q[$].code != dir_tab[i].code)) begin
        $error("table row %0d: predictor disagrees with kind %0d code %0d",
               i, dir_tab[i].kind, dir_tab[i].code);
        errs++;
      end
    end

    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 16 : (m == 1) ? 68 : 0;
      recv_idle = (m == 0) ? 68 : (m == 1) ? 16 : 0;
      sent = 0;
      held = 1'b0;
      while (sent < 40) begin
        sent += gen_doc(m == 2 && sent == 0);
        if (!held && sent > 20) begin
          // hold the request side until the results catch up
          held = 1'b1;
          hold = 1'b1;
          while (push || want_q.size() != queued_events()) @(posedge clk_i);
          hold = 1'b0;
        end
        while (req_q.size() > 40) @(posedge clk_i);
      end
    end

    while (req_q.size() > 0 || push || want_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0 && want_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
